[rtl/esd_pkg.sv]
// Shared types, character codes, escape spellings and the sequencer program.
`default_nettype none

package esd_pkg;

    localparam int WinDepth  = 7;
    localparam int FormCount = 6;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_count;
    typedef logic [1:0] t_step;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_ACC,
        COND_DONE,
        COND_OUT_ACC
    } t_cond;

    typedef struct packed {
        logic  in_rdy;
        logic  load;
        logic  capture;
        logic  out_vld;
        logic  shift;
        t_cond cond;
        t_step jump_t;
        t_step jump_f;
    } t_ctrl;

    typedef struct packed {
        t_byte  dec_byte;
        t_count used;
    } t_dec;

    localparam t_step STEP_FETCH  = 2'd0;
    localparam t_step STEP_DECIDE = 2'd1;
    localparam t_step STEP_EMIT   = 2'd2;
    localparam t_step STEP_SPARE  = 2'd3;

    localparam t_ctrl PROGRAM [4] = '{
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, COND_IN_ACC,  STEP_DECIDE, STEP_FETCH},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, COND_DONE,    STEP_FETCH,  STEP_EMIT},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, COND_OUT_ACC, STEP_DECIDE, STEP_EMIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,  STEP_FETCH,  STEP_FETCH}
    };

    localparam t_byte CH_BSL   = 8'h5C;
    localparam t_byte CH_ESC   = 8'h1B;
    localparam t_byte CH_N     = 8'h6E;
    localparam t_byte CH_R     = 8'h72;
    localparam t_byte CH_T     = 8'h74;
    localparam t_byte CH_B     = 8'h62;
    localparam t_byte CH_F     = 8'h66;
    localparam t_byte CH_V     = 8'h76;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_U     = 8'h75;
    localparam t_byte CH_X     = 8'h78;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_1     = 8'h31;
    localparam t_byte CH_3     = 8'h33;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_BS    = 8'h08;
    localparam t_byte CH_FF    = 8'h0C;
    localparam t_byte CH_VT    = 8'h0B;
    localparam t_byte CH_NUL   = 8'h00;

    localparam t_byte FORMS [FormCount][WinDepth] = '{
        '{CH_BSL, CH_U,   CH_0, CH_0, CH_1,   CH_B,   CH_NUL},
        '{CH_BSL, CH_BSL, CH_U, CH_0, CH_0,   CH_1,   CH_B},
        '{CH_BSL, CH_0,   CH_3, CH_3, CH_NUL, CH_NUL, CH_NUL},
        '{CH_BSL, CH_BSL, CH_0, CH_3, CH_3,   CH_NUL, CH_NUL},
        '{CH_BSL, CH_X,   CH_1, CH_B, CH_NUL, CH_NUL, CH_NUL},
        '{CH_BSL, CH_BSL, CH_X, CH_1, CH_B,   CH_NUL, CH_NUL}
    };

    localparam t_count FORM_LEN [FormCount] = '{3'd6, 3'd7, 3'd4, 3'd5, 3'd4, 3'd5};

endpackage

`default_nettype wire

[rtl/esd_if.sv]
// Handshake interfaces for the raw and decoded byte channels.
`default_nettype none

interface esd_in_if;
    logic          valid;
    logic          ready;
    esd_pkg::t_byte in_byte;
    logic          in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic          valid;
    logic          ready;
    esd_pkg::t_byte out_byte;
    logic          out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[rtl/escape_sequence_decoder_top.sv]
// Backslash escape decoder top level: microcoded sequencer and lookahead window.
// Items are loaded in fetch; decide captures a result, held in emit until taken.
// A new item is taken only in fetch, once decide finds no more to emit; the
// three-step program (fetch, decide, emit) handles one decision per pass.
// Reset: synchronous, active low; clears the step counter and the pending count.
`default_nettype none

module escape_sequence_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esd_in_if.sink     i_in,
    esd_out_if.source  o_out
);
    import esd_pkg::*;

    t_byte  r_win [WinDepth];
    t_byte  n_win [WinDepth];
    t_count r_count;
    t_count n_count;
    t_step  r_step;
    t_step  n_step;
    logic   r_last;
    t_byte  r_out_byte;
    logic   r_out_last;
    t_count r_used;
    t_ctrl  ctrl;
    logic   cond_hit;
    t_dec   dec;

    esd_decide u_decide (
        .i_win   (r_win),
        .i_avail (r_count),
        .i_last  (r_last),
        .o_dec   (dec)
    );

    assign ctrl = PROGRAM[r_step];

    always_comb begin
        unique case (ctrl.cond)
            COND_ALWAYS:  cond_hit = 1'b1;
            COND_IN_ACC:  cond_hit = i_in.valid;
            COND_DONE:    cond_hit = (r_count == 3'd0) || (dec.used == 3'd0);
            COND_OUT_ACC: cond_hit = o_out.ready;
            default:      cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        n_step = cond_hit ? ctrl.jump_t : ctrl.jump_f;
    end

    always_comb begin
        i_in.ready     = ctrl.in_rdy;
        o_out.valid    = ctrl.out_vld;
        o_out.out_byte = r_out_byte;
        o_out.out_last = r_out_last;
    end

    always_comb begin
        logic [3:0] idx;
        idx     = 4'd0;
        n_win   = r_win;
        n_count = r_count;
        if (ctrl.load && cond_hit) begin
            n_win[r_count] = i_in.in_byte;
            n_count        = r_count + 3'd1;
        end
        if (ctrl.shift && cond_hit) begin
            for (int i = 0; i < WinDepth; i++) begin
                idx = 4'(i) + {1'b0, r_used};
                if (idx < 4'(WinDepth)) begin
                    n_win[i] = r_win[idx[2:0]];
                end
            end
            n_count = r_count - r_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_FETCH;
            r_count <= 3'd0;
        end else begin
            r_step  <= n_step;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (ctrl.load && cond_hit) begin
            r_last <= i_in.in_last;
        end
        if (ctrl.capture) begin
            r_out_byte <= dec.dec_byte;
            r_used     <= dec.used;
            r_out_last <= r_last && (r_count == dec.used);
        end
    end

endmodule

`default_nettype wire

[rtl/esd_decide.sv]
// Escape match and decode decision on the head of the lookahead window.
`default_nettype none

module esd_decide (
    input  esd_pkg::t_byte  i_win [esd_pkg::WinDepth],
    input  esd_pkg::t_count i_avail,
    input  logic            i_last,
    output esd_pkg::t_dec   o_dec
);
    import esd_pkg::*;

    logic [WinDepth-1:0] eq   [FormCount];
    logic [WinDepth:0]   pre  [FormCount];
    logic [FormCount-1:0] full;
    logic [FormCount-1:0] part;
    logic                simple_hit;
    t_byte               simple_byte;

    always_comb begin
        for (int k = 0; k < FormCount; k++) begin
            pre[k][0] = 1'b1;
            for (int j = 0; j < WinDepth; j++) begin
                eq[k][j]    = (i_win[j] == FORMS[k][j]);
                pre[k][j+1] = pre[k][j] & eq[k][j];
            end
            full[k] = (i_avail >= FORM_LEN[k]) && pre[k][FORM_LEN[k]];
            part[k] = (i_avail < FORM_LEN[k]) && pre[k][i_avail];
        end
    end

    always_comb begin
        simple_hit  = 1'b1;
        simple_byte = CH_BSL;
        unique case (i_win[1])
            CH_N:     simple_byte = CH_LF;
            CH_R:     simple_byte = CH_CR;
            CH_T:     simple_byte = CH_TAB;
            CH_B:     simple_byte = CH_BS;
            CH_F:     simple_byte = CH_FF;
            CH_V:     simple_byte = CH_VT;
            CH_BSL:   simple_byte = CH_BSL;
            CH_QUOTE: simple_byte = CH_QUOTE;
            CH_SLASH: simple_byte = CH_SLASH;
            default:  simple_hit  = 1'b0;
        endcase
    end

    always_comb begin
        logic found;
        found          = 1'b0;
        o_dec.dec_byte = CH_BSL;
        o_dec.used     = 3'd1;
        if (i_win[0] != CH_BSL) begin
            o_dec.dec_byte = i_win[0];
        end else begin
            for (int k = 0; k < FormCount; k++) begin
                if (!found) begin
                    if (full[k]) begin
                        o_dec.dec_byte = CH_ESC;
                        o_dec.used     = FORM_LEN[k];
                        found          = 1'b1;
                    end else if (part[k] && !i_last) begin
                        o_dec.used = 3'd0;
                        found      = 1'b1;
                    end
                end
            end
            if (!found) begin
                if (i_avail < 3'd2) begin
                    if (!i_last) begin
                        o_dec.used = 3'd0;
                    end
                end else if (simple_hit) begin
                    o_dec.dec_byte = simple_byte;
                    o_dec.used     = 3'd2;
                end
            end
        end
    end

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for the escape decoder: a byte-stream predictor checks each decoded item.
`timescale 1ns / 1ps

module tb;
    import esd_pkg::*;

    localparam int CycleLimit    = 400000;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 40;
    localparam int PhaseBytes    = 170;
    localparam int SpellCount    = 6;
    localparam int ScanDepth     = 7;

    typedef enum int {
        MATCH_NONE,
        MATCH_FULL,
        MATCH_SHORT
    } t_match;

    typedef struct {
        t_byte ch;
        logic  fin;
    } t_text_char;

    localparam t_byte ESC_SPELL [SpellCount][ScanDepth] = '{
        '{CH_BSL, CH_U,   CH_0, CH_0, CH_1,   CH_B,   CH_NUL},
        '{CH_BSL, CH_BSL, CH_U, CH_0, CH_0,   CH_1,   CH_B},
        '{CH_BSL, CH_0,   CH_3, CH_3, CH_NUL, CH_NUL, CH_NUL},
        '{CH_BSL, CH_BSL, CH_0, CH_3, CH_3,   CH_NUL, CH_NUL},
        '{CH_BSL, CH_X,   CH_1, CH_B, CH_NUL, CH_NUL, CH_NUL},
        '{CH_BSL, CH_BSL, CH_X, CH_1, CH_B,   CH_NUL, CH_NUL}
    };
    localparam int SPELL_LEN [SpellCount] = '{6, 7, 4, 5, 4, 5};
    localparam t_byte SIMPLE_KEYS [9] = '{
        CH_N, CH_R, CH_T, CH_B, CH_F, CH_V, CH_BSL, CH_QUOTE, CH_SLASH
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    esd_in_if  raw_if ();
    esd_out_if dec_if ();

    escape_sequence_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (raw_if),
        .o_out   (dec_if)
    );

    always #2 i_clk = ~i_clk;

    t_text_char raw_pending [$];
    t_text_char decoded_due [$];
    t_byte      text_buf [$];

    t_byte scan_win [ScanDepth];
    t_byte held_bytes [ScanDepth];
    int    held_count = 0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_asked = 0;
    int  stall_seen = 0;
    int  stall_left = 0;
    bit  raw_taken = 1'b0;
    int  cycle_count = 0;
    int  error_count = 0;
    int  bytes_queued = 0;
    int  strings_queued = 0;
    int  bytes_in = 0;
    int  chars_out = 0;

    function automatic t_match spell_match(int base, int avail, int k);
        for (int j = 0; j < SPELL_LEN[k]; j++) begin
            if (j >= avail) return MATCH_SHORT;
            if (scan_win[base + j] != ESC_SPELL[k][j]) return MATCH_NONE;
        end
        return MATCH_FULL;
    endfunction

    function automatic bit simple_escape(t_byte key, output t_byte ch);
        ch = key;
        case (key)
            CH_N:     ch = CH_LF;
            CH_R:     ch = CH_CR;
            CH_T:     ch = CH_TAB;
            CH_B:     ch = CH_BS;
            CH_F:     ch = CH_FF;
            CH_V:     ch = CH_VT;
            CH_BSL, CH_QUOTE, CH_SLASH: ch = key;
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic int decode_one(int base, int avail, bit fin, output t_byte ch);
        t_match m;
        t_byte  mapped;
        ch = scan_win[base];
        if (scan_win[base] != CH_BSL) return 1;
        for (int k = 0; k < SpellCount; k++) begin
            m = spell_match(base, avail, k);
            if (m == MATCH_FULL) begin
                ch = CH_ESC;
                return SPELL_LEN[k];
            end
            if (m == MATCH_SHORT && !fin) return 0;
        end
        if (avail < 2) begin
            if (!fin) return 0;
            ch = CH_BSL;
            return 1;
        end
        if (simple_escape(scan_win[base + 1], mapped)) begin
            ch = mapped;
            return 2;
        end
        ch = CH_BSL;
        return 1;
    endfunction

    function automatic void decode_byte(t_byte b, bit fin);
        int    n;
        int    pos;
        int    used;
        int    first_new;
        t_byte ch;
        n = held_count;
        for (int j = 0; j < n; j++) scan_win[j] = held_bytes[j];
        scan_win[n] = b;
        n++;
        pos = 0;
        first_new = decoded_due.size();
        while (pos < n) begin
            used = decode_one(pos, n - pos, fin, ch);
            if (used == 0) break;
            decoded_due.push_back('{ch: ch, fin: 1'b0});
            pos += used;
        end
        if (fin) begin
            if (decoded_due.size() > first_new) decoded_due[decoded_due.size() - 1].fin = 1'b1;
            held_count = 0;
        end else begin
            for (int j = 0; j < n - pos; j++) held_bytes[j] = scan_win[pos + j];
            held_count = n - pos;
        end
    endfunction

    task automatic queue_string();
        for (int i = 0; i < text_buf.size(); i++) begin
            raw_pending.push_back('{ch: text_buf[i], fin: (i == text_buf.size() - 1)});
            bytes_queued++;
        end
        strings_queued++;
        text_buf.delete();
    endtask

    task automatic add_literal(string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(t_byte'(s[i]));
    endtask

    task automatic add_spelling(int k, int len);
        for (int j = 0; j < len; j++) text_buf.push_back(ESC_SPELL[k][j]);
    endtask

    task automatic add_random_string();
        int kind;
        int k;
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(99);
            k = $urandom_range(SpellCount - 1);
            if (kind < 25) begin
                text_buf.push_back(t_byte'($urandom_range(255)));
            end else if (kind < 50) begin
                add_spelling(k, SPELL_LEN[k]);
            end else if (kind < 70) begin
                text_buf.push_back(CH_BSL);
                text_buf.push_back(SIMPLE_KEYS[$urandom_range(8)]);
            end else if (kind < 88) begin
                add_spelling(k, $urandom_range(1, SPELL_LEN[k] - 1));
            end else begin
                text_buf.push_back(CH_BSL);
                text_buf.push_back(t_byte'($urandom_range(255)));
            end
        end
        queue_string();
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (raw_pending.size() > 0 || raw_if.valid || decoded_due.size() > 0);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            raw_if.valid   <= 1'b0;
            raw_if.in_byte <= '0;
            raw_if.in_last <= 1'b0;
        end else if (!raw_if.valid || raw_taken) begin
            if (raw_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                raw_if.valid   <= 1'b1;
                raw_if.in_byte <= raw_pending[0].ch;
                raw_if.in_last <= raw_pending[0].fin;
                void'(raw_pending.pop_front());
            end else begin
                raw_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_asked != stall_seen) begin
            stall_seen = stall_asked;
            stall_left = HoldOffCycles;
        end
        if (!i_rst_n) begin
            dec_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            dec_if.ready <= 1'b0;
        end else begin
            dec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_text_char want;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            raw_taken = i_rst_n && raw_if.valid && raw_if.ready;
            if (i_rst_n && dec_if.valid && dec_if.ready) begin
                chars_out++;
                if (decoded_due.size() == 0) begin
                    $error("out_byte: expected nothing, actual %02h", dec_if.out_byte);
                    error_count++;
                end else begin
                    want = decoded_due.pop_front();
                    if (dec_if.out_byte !== want.ch) begin
                        $error("out_byte: expected %02h, actual %02h", want.ch, dec_if.out_byte);
                        error_count++;
                    end
                    if (dec_if.out_last !== want.fin) begin
                        $error("out_last: expected %0b, actual %0b", want.fin, dec_if.out_last);
                        error_count++;
                    end
                end
            end
            if (raw_taken) begin
                bytes_in++;
                decode_byte(raw_if.in_byte, raw_if.in_last);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 27;
        recv_idle_pct = 79;
        add_literal("\\u001b");
        queue_string();
        add_literal("\\\\033\\n");
        queue_string();
        add_literal("\\x1b");
        queue_string();
        add_literal("\\q");
        queue_string();
        add_literal("\\u0");
        queue_string();
        text_buf.push_back(CH_NUL);
        text_buf.push_back(8'hFF);
        queue_string();
        text_buf.push_back(CH_BSL);
        queue_string();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 79;
                recv_idle_pct = 27;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stall_asked++;
            end
            while (bytes_queued < 25 + (phase + 1) * PhaseBytes) add_random_string();
            wait_for_drain();
        end

        repeat (DrainCycles) @(posedge i_clk);
        $display("Covered %0d strings: %0d raw bytes in, %0d decoded items out,",
                 strings_queued, bytes_in, chars_out);
        $display("under both idling mixes, a long output hold-off and unthrottled streaming.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
